>>> src/biu_pkg.sv
// Shared types and constants for the bilinear image upscaler.
// Holds the transaction structs, register indexes and fixed field widths.
// No dependencies.
package biu_pkg;

	// Fixed field widths.
	localparam int COORD_BITS = 12;
	localparam int CHAN_BITS  = 8;
	localparam int SIZE_BITS  = 9;
	localparam int STEP_BITS  = 17;
	localparam int FRAC_BITS  = 16;
	localparam int POS_BITS   = COORD_BITS + STEP_BITS;
	localparam int INT_BITS   = POS_BITS - FRAC_BITS;
	localparam int WGT_BITS   = 2 * STEP_BITS - 1;
	localparam int PROD_BITS  = CHAN_BITS + WGT_BITS;

	// Configuration port.
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = STEP_BITS;

	localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_HEIGHT = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_X        = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_Y        = 2'd3;

	// Operation codes of an input transaction.
	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	// Register reset values.
	localparam logic [SIZE_BITS-1:0] SIZE_RESET = 9'd256;
	localparam logic [STEP_BITS-1:0] STEP_RESET = 17'h10000;

	typedef struct packed {
		logic                  operation;
		logic [COORD_BITS-1:0] column;
		logic [COORD_BITS-1:0] row;
		logic [CHAN_BITS-1:0]  red_in;
		logic [CHAN_BITS-1:0]  green_in;
		logic [CHAN_BITS-1:0]  blue_in;
	} in_item_t;

	typedef struct packed {
		logic [CHAN_BITS-1:0] red_out;
		logic [CHAN_BITS-1:0] green_out;
		logic [CHAN_BITS-1:0] blue_out;
	} out_item_t;

	typedef struct packed {
		logic [CHAN_BITS-1:0] red;
		logic [CHAN_BITS-1:0] green;
		logic [CHAN_BITS-1:0] blue;
	} pixel_t;

	typedef logic [WGT_BITS-1:0] weight_t;

endpackage

>>> src/biu_bank.sv
// One bank of the source pixel memory: one write port, one registered read port.
// Depends on biu_pkg for the pixel type.
module biu_bank #(
	parameter int DEPTH = 16641,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  biu_pkg::pixel_t wdata,
	input  logic [AW-1:0]   raddr,
	output biu_pkg::pixel_t rdata
);
	import biu_pkg::*;

	pixel_t mem [DEPTH];
	pixel_t rdata_q;

	// Read returns the old contents when the same entry is written at the same edge.
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/biu_blend.sv
// Weighted sum of four neighbour pixels per channel, two register stages.
// Depends on biu_pkg for pixel, weight and result types.
module biu_blend (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  biu_pkg::pixel_t [3:0]       pix,
	input  biu_pkg::weight_t [3:0]      wgt,
	output logic                        out_valid,
	output biu_pkg::out_item_t          result
);
	import biu_pkg::*;

	logic                 valid_s1;
	logic [PROD_BITS-1:0] prod_r_s1 [4];
	logic [PROD_BITS-1:0] prod_g_s1 [4];
	logic [PROD_BITS-1:0] prod_b_s1 [4];
	logic [PROD_BITS-1:0] sum_r;
	logic [PROD_BITS-1:0] sum_g;
	logic [PROD_BITS-1:0] sum_b;
	logic                 valid_q;
	out_item_t            result_q;

	// Control: valid bits through the two stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_q  <= valid_s1;
		end
	end

	// First stage: one product per channel and neighbour.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			prod_r_s1[i] <= PROD_BITS'(pix[i].red)   * PROD_BITS'(wgt[i]);
			prod_g_s1[i] <= PROD_BITS'(pix[i].green) * PROD_BITS'(wgt[i]);
			prod_b_s1[i] <= PROD_BITS'(pix[i].blue)  * PROD_BITS'(wgt[i]);
		end
	end

	// The weights total exactly 2^32, so each sum stays below 2^40.
	always_comb begin
		sum_r = prod_r_s1[0] + prod_r_s1[1] + prod_r_s1[2] + prod_r_s1[3];
		sum_g = prod_g_s1[0] + prod_g_s1[1] + prod_g_s1[2] + prod_g_s1[3];
		sum_b = prod_b_s1[0] + prod_b_s1[1] + prod_b_s1[2] + prod_b_s1[3];
	end

	// Second stage: keep the integer part of each channel.
	always_ff @(posedge clk) begin
		result_q.red_out   <= sum_r[2*FRAC_BITS +: CHAN_BITS];
		result_q.green_out <= sum_g[2*FRAC_BITS +: CHAN_BITS];
		result_q.blue_out  <= sum_b[2*FRAC_BITS +: CHAN_BITS];
	end

	assign out_valid = valid_q;
	assign result    = result_q;

endmodule

>>> src/bilinear_image_upscaler_unit.sv
// Top level of the bilinear image upscaler: configuration, address pipeline,
// four-bank source memory and the blend stage.
// Depends on biu_pkg, biu_bank and biu_blend.
//
// Usage: a transaction is accepted at a rising edge with start high and busy low.
// busy is never raised, so one transaction may be accepted every cycle.
// A write transaction (operation 0) stores a pixel at column and row if it lies
// inside the frame in use, and returns nothing. A request transaction
// (operation 1) returns one interpolated pixel: done is high for exactly one
// cycle, with the pixel on result. Results leave in acceptance order and the
// receiver cannot hold them off.
// The source frame is split into four banks by column and row parity, so the
// four neighbours of a request are read at one edge; this sets the rate of one
// transaction per cycle. Writes travel down the pipeline in registers and reach
// the memory at the same pipeline stage where requests read it, so every request
// sees exactly the writes accepted before it.
// Registers are written through write_enable, reg_index and write_data; the user
// must write them only while no transaction is in flight, as the block does not
// enforce it. Reset restores the register defaults and empties the pipeline; the
// pixel memory is not cleared and must be loaded before it is read.
module bilinear_image_upscaler_unit #(
	parameter int MAX_SOURCE_WIDTH  = 256,
	parameter int MAX_SOURCE_HEIGHT = 256
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  biu_pkg::in_item_t                     cmd,
	output logic                                  done,
	output biu_pkg::out_item_t                    result,
	input  logic                                  write_enable,
	input  logic [biu_pkg::CFG_INDEX_BITS-1:0]    reg_index,
	input  logic [biu_pkg::CFG_DATA_BITS-1:0]     write_data
);
	import biu_pkg::*;

	localparam int WW         = $clog2(MAX_SOURCE_WIDTH + 1);
	localparam int HW         = $clog2(MAX_SOURCE_HEIGHT + 1);
	localparam int CB         = $clog2(MAX_SOURCE_WIDTH);
	localparam int RB         = $clog2(MAX_SOURCE_HEIGHT);
	localparam int CWW        = (WW > SIZE_BITS) ? WW : SIZE_BITS;
	localparam int CHW        = (HW > SIZE_BITS) ? HW : SIZE_BITS;
	localparam int BANK_COLS  = MAX_SOURCE_WIDTH / 2 + 1;
	localparam int BANK_ROWS  = MAX_SOURCE_HEIGHT / 2 + 1;
	localparam int BANK_DEPTH = BANK_COLS * BANK_ROWS;
	localparam int AW         = $clog2(BANK_DEPTH);

	// Configuration registers.
	logic [SIZE_BITS-1:0] width_q;
	logic [SIZE_BITS-1:0] height_q;
	logic [STEP_BITS-1:0] step_x_q;
	logic [STEP_BITS-1:0] step_y_q;

	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;

	// Pipeline registers.
	logic                 v_s1;
	in_item_t             item_s1;
	logic                 req_s2;
	logic [INT_BITS-1:0]  ix_s2;
	logic [INT_BITS-1:0]  iy_s2;
	logic [FRAC_BITS-1:0] fx_s2;
	logic [FRAC_BITS-1:0] fy_s2;
	logic [3:0]           bank_we_s2;
	logic [AW-1:0]        waddr_s2;
	pixel_t               wdata_s2;
	logic                 req_s3;
	logic [CB-1:0]        x1_s3;
	logic [RB-1:0]        y1_s3;
	logic                 edge_x_s3;
	logic                 edge_y_s3;
	logic [FRAC_BITS-1:0] fx_s3;
	logic [FRAC_BITS-1:0] fy_s3;
	logic [3:0]           bank_we_s3;
	logic [AW-1:0]        waddr_s3;
	pixel_t               wdata_s3;
	logic                 req_s4;
	weight_t [3:0]        wgt_s4;
	logic                 px_s4;
	logic                 py_s4;
	logic                 qx_s4;
	logic                 qy_s4;

	// Combinational signals.
	logic [POS_BITS-1:0]  pos_x;
	logic [POS_BITS-1:0]  pos_y;
	logic                 in_frame;
	logic [3:0]           bank_we;
	logic [AW-1:0]        bank_waddr;
	pixel_t               bank_wdata;
	logic [CB-1:0]        x1;
	logic [RB-1:0]        y1;
	logic                 edge_x;
	logic                 edge_y;
	logic [AW-1:0]        bank_raddr [4];
	pixel_t               bank_rdata [4];
	weight_t [3:0]        wgt;
	pixel_t [3:0]         nbr;

	// The input side never stalls.
	assign busy = 1'b0;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_RESET;
			height_q <= SIZE_RESET;
			step_x_q <= STEP_RESET;
			step_y_q <= STEP_RESET;
		end else if (write_enable) begin
			unique case (reg_index)
				REG_SOURCE_WIDTH:  width_q  <= write_data[SIZE_BITS-1:0];
				REG_SOURCE_HEIGHT: height_q <= write_data[SIZE_BITS-1:0];
				REG_STEP_X:        step_x_q <= write_data;
				REG_STEP_Y:        step_y_q <= write_data;
			endcase
		end
	end

	// Frame size in use: zero acts as one, anything above the maximum as the maximum.
	always_comb begin
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (CWW'(width_q) > CWW'(MAX_SOURCE_WIDTH)) begin
			w_eff = WW'(MAX_SOURCE_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HW'(1);
		end else if (CHW'(height_q) > CHW'(MAX_SOURCE_HEIGHT)) begin
			h_eff = HW'(MAX_SOURCE_HEIGHT);
		end else begin
			h_eff = HW'(height_q);
		end
	end

	// Pipeline control: valid and request flags, and the delayed bank write enables.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			req_s2     <= 1'b0;
			req_s3     <= 1'b0;
			req_s4     <= 1'b0;
			bank_we_s2 <= '0;
			bank_we_s3 <= '0;
		end else begin
			v_s1       <= start && !busy;
			req_s2     <= v_s1 && (item_s1.operation == OP_REQUEST);
			req_s3     <= req_s2;
			req_s4     <= req_s3;
			bank_we_s2 <= bank_we;
			bank_we_s3 <= bank_we_s2;
		end
	end

	// Stage 1 capture of the accepted transaction.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= cmd;
		end
	end

	// Stage 1: source position and the write into the bank of matching parity.
	always_comb begin
		pos_x      = POS_BITS'(item_s1.column) * POS_BITS'(step_x_q);
		pos_y      = POS_BITS'(item_s1.row) * POS_BITS'(step_y_q);
		in_frame   = ({1'b0, item_s1.column} < INT_BITS'(w_eff))
		          && ({1'b0, item_s1.row} < INT_BITS'(h_eff));
		bank_we    = '0;
		if (v_s1 && (item_s1.operation == OP_WRITE) && in_frame) begin
			bank_we[{item_s1.row[0], item_s1.column[0]}] = 1'b1;
		end
		bank_waddr = AW'(item_s1.row >> 1) * AW'(BANK_COLS) + AW'(item_s1.column >> 1);
		bank_wdata = '{red: item_s1.red_in, green: item_s1.green_in,
		               blue: item_s1.blue_in};
	end

	always_ff @(posedge clk) begin
		ix_s2 <= pos_x[POS_BITS-1:FRAC_BITS];
		iy_s2 <= pos_y[POS_BITS-1:FRAC_BITS];
		fx_s2 <= pos_x[FRAC_BITS-1:0];
		fy_s2 <= pos_y[FRAC_BITS-1:0];
	end

	// The write is carried down to the read stage, so that a request never sees
	// a write accepted after it.
	always_ff @(posedge clk) begin
		waddr_s2 <= bank_waddr;
		wdata_s2 <= bank_wdata;
		waddr_s3 <= waddr_s2;
		wdata_s3 <= wdata_s2;
	end

	// Stage 2: clamp the top-left neighbour and flag the last column or row.
	always_comb begin
		x1     = (ix_s2 < INT_BITS'(w_eff)) ? CB'(ix_s2) : CB'(w_eff - WW'(1));
		y1     = (iy_s2 < INT_BITS'(h_eff)) ? RB'(iy_s2) : RB'(h_eff - HW'(1));
		edge_x = (WW'(x1) + WW'(1)) >= w_eff;
		edge_y = (HW'(y1) + HW'(1)) >= h_eff;
	end

	always_ff @(posedge clk) begin
		x1_s3     <= x1;
		y1_s3     <= y1;
		edge_x_s3 <= edge_x;
		edge_y_s3 <= edge_y;
		fx_s3     <= fx_s2;
		fy_s3     <= fy_s2;
	end

	// Stage 3: bank read addresses. An odd bank holds x1 or x1+1, whichever is odd.
	always_comb begin
		logic [CB-1:0] ci;
		logic [RB-1:0] ri;
		ci = '0;
		ri = '0;
		for (int b = 0; b < 4; b++) begin
			ci = (b % 2 == 1) ? CB'(x1_s3 >> 1) : CB'(({1'b0, x1_s3} + 1'b1) >> 1);
			ri = (b / 2 == 1) ? RB'(y1_s3 >> 1) : RB'(({1'b0, y1_s3} + 1'b1) >> 1);
			bank_raddr[b] = AW'(ri) * AW'(BANK_COLS) + AW'(ci);
		end
	end

	// Stage 3: the four bilinear weights from the fractions.
	always_comb begin
		logic [STEP_BITS-1:0] ifx;
		logic [STEP_BITS-1:0] ify;
		ifx    = STEP_RESET - STEP_BITS'(fx_s3);
		ify    = STEP_RESET - STEP_BITS'(fy_s3);
		wgt[0] = WGT_BITS'(ifx) * WGT_BITS'(ify);
		wgt[1] = WGT_BITS'(fx_s3) * WGT_BITS'(ify);
		wgt[2] = WGT_BITS'(ifx) * WGT_BITS'(fy_s3);
		wgt[3] = WGT_BITS'(fx_s3) * WGT_BITS'(fy_s3);
	end

	always_ff @(posedge clk) begin
		wgt_s4 <= wgt;
		px_s4  <= x1_s3[0];
		py_s4  <= y1_s3[0];
		qx_s4  <= edge_x_s3 ? x1_s3[0] : !x1_s3[0];
		qy_s4  <= edge_y_s3 ? y1_s3[0] : !y1_s3[0];
	end

	// Source pixel memory in four parity banks.
	for (genvar b = 0; b < 4; b++) begin : g_bank
		biu_bank #(
			.DEPTH(BANK_DEPTH)
		) u_bank (
			.clk  (clk),
			.we   (bank_we_s3[b]),
			.waddr(waddr_s3),
			.wdata(wdata_s3),
			.raddr(bank_raddr[b]),
			.rdata(bank_rdata[b])
		);
	end

	// Stage 4: route bank outputs to the four neighbours; at an edge the second
	// neighbour repeats the first.
	always_comb begin
		nbr[0] = bank_rdata[{py_s4, px_s4}];
		nbr[1] = bank_rdata[{py_s4, qx_s4}];
		nbr[2] = bank_rdata[{qy_s4, px_s4}];
		nbr[3] = bank_rdata[{qy_s4, qx_s4}];
	end

	biu_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req_s4),
		.pix      (nbr),
		.wgt      (wgt_s4),
		.out_valid(done),
		.result   (result)
	);

	// A result appears only when a request transaction was accepted earlier.
	a_done_from_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && (cmd.operation == OP_REQUEST), 6))
		else $error("result without a matching request transaction");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		$past(start && !busy && (cmd.operation == OP_WRITE), 6) |-> !done)
		else $error("write transaction produced a result");

	// A write lands in at most one bank, and only for a write transaction.
	a_single_bank_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(bank_we_s3) && ((bank_we_s3 == '0) || $past(start && !busy
			&& (cmd.operation == OP_WRITE), 3)))
		else $error("bank write enables inconsistent");

endmodule

>>> bench/biu_checker.sv
// Checker for the bilinear image upscaler: watches the command, result and register ports,
// predicts each interpolated pixel and compares it with what the block returns.
// Depends on biu_pkg.
`timescale 1ns / 1ps
module biu_checker #(
	parameter int MAX_W = 256,
	parameter int MAX_H = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  biu_pkg::in_item_t                  cmd,
	input  logic                               done,
	input  biu_pkg::out_item_t                 result,
	input  logic                               write_enable,
	input  logic [biu_pkg::CFG_INDEX_BITS-1:0] reg_index,
	input  logic [biu_pkg::CFG_DATA_BITS-1:0]  write_data,
	output int                                 fail_count,
	output int                                 pending_count
);
	import biu_pkg::*;

	// Shadow copy of the source frame and of the registers.
	pixel_t                frame_mem [MAX_W*MAX_H];
	logic [SIZE_BITS-1:0]  width_reg;
	logic [SIZE_BITS-1:0]  height_reg;
	logic [STEP_BITS-1:0]  step_x_reg;
	logic [STEP_BITS-1:0]  step_y_reg;
	out_item_t             pixel_queue [$];
	int                    mismatches;
	string                 chan_name [3] = '{"red", "green", "blue"};

	// A size of zero behaves as one, and anything past the memory as the maximum.
	function automatic int unsigned used_size(logic [SIZE_BITS-1:0] v, int unsigned maxv);
		if (v == 0)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	// Weighted sum of one channel over the four neighbours, floored by 2^32.
	function automatic logic [CHAN_BITS-1:0] blend_channel(
		logic [CHAN_BITS-1:0] a, logic [CHAN_BITS-1:0] b,
		logic [CHAN_BITS-1:0] c, logic [CHAN_BITS-1:0] d,
		longint unsigned w0, longint unsigned w1,
		longint unsigned w2, longint unsigned w3);
		longint unsigned acc;
		acc = a * w0 + b * w1 + c * w2 + d * w3;
		return CHAN_BITS'(acc >> 32);
	endfunction

	// Expected output pixel for a request at an output column and row.
	function automatic out_item_t interpolate(logic [COORD_BITS-1:0] col,
		logic [COORD_BITS-1:0] row);
		int unsigned     w, h, posx, posy, ix, iy, x1, x2, y1, y2;
		longint unsigned fx, fy, w0, w1, w2, w3;
		pixel_t          p1, p2, p3, p4;
		out_item_t       o;
		w    = used_size(width_reg, MAX_W);
		h    = used_size(height_reg, MAX_H);
		posx = col * step_x_reg;
		posy = row * step_y_reg;
		ix   = posx >> FRAC_BITS;
		iy   = posy >> FRAC_BITS;
		fx   = posx & 32'hFFFF;
		fy   = posy & 32'hFFFF;
		// Past the frame the integer part sticks to the last column or row.
		x1 = (ix < w) ? ix : w - 1;
		y1 = (iy < h) ? iy : h - 1;
		x2 = (x1 + 1 < w) ? x1 + 1 : x1;
		y2 = (y1 + 1 < h) ? y1 + 1 : y1;
		p1 = frame_mem[y1*MAX_W + x1];
		p2 = frame_mem[y1*MAX_W + x2];
		p3 = frame_mem[y2*MAX_W + x1];
		p4 = frame_mem[y2*MAX_W + x2];
		w0 = (65536 - fx) * (65536 - fy);
		w1 = fx * (65536 - fy);
		w2 = (65536 - fx) * fy;
		w3 = fx * fy;
		o.red_out   = blend_channel(p1.red, p2.red, p3.red, p4.red, w0, w1, w2, w3);
		o.green_out = blend_channel(p1.green, p2.green, p3.green, p4.green, w0, w1, w2, w3);
		o.blue_out  = blend_channel(p1.blue, p2.blue, p3.blue, p4.blue, w0, w1, w2, w3);
		return o;
	endfunction

	// Track every transaction at the clock edge that accepts it.
	always @(posedge clk or negedge arst_n) begin
		out_item_t expected;
		if (!arst_n) begin
			width_reg  = SIZE_RESET;
			height_reg = SIZE_RESET;
			step_x_reg = STEP_RESET;
			step_y_reg = STEP_RESET;
			pixel_queue.delete();
			mismatches = 0;
		end else begin
			// Results leave in acceptance order, so each one meets the oldest prediction.
			if (done) begin
				if (pixel_queue.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, actual %h", $time, result);
				end else begin
					expected = pixel_queue.pop_front();
					for (int k = 0; k < 3; k++) begin
						if (result[23-8*k -: 8] !== expected[23-8*k -: 8]) begin
							mismatches++;
							$display("%0t: %s mismatch, expected %h, actual %h", $time,
								chan_name[k], expected[23-8*k -: 8], result[23-8*k -: 8]);
						end
					end
				end
			end
			// Register writes.
			if (write_enable) begin
				case (reg_index)
					REG_SOURCE_WIDTH:  width_reg  = write_data[SIZE_BITS-1:0];
					REG_SOURCE_HEIGHT: height_reg = write_data[SIZE_BITS-1:0];
					REG_STEP_X:        step_x_reg = write_data[STEP_BITS-1:0];
					REG_STEP_Y:        step_y_reg = write_data[STEP_BITS-1:0];
					default: ;
				endcase
			end
			// Command transactions: requests queue a prediction, writes update the frame.
			if (start && !busy) begin
				if (cmd.operation == OP_REQUEST)
					pixel_queue.push_back(interpolate(cmd.column, cmd.row));
				else if (cmd.column < used_size(width_reg, MAX_W) &&
					cmd.row < used_size(height_reg, MAX_H))
					frame_mem[cmd.row*MAX_W + cmd.column] =
						'{cmd.red_in, cmd.green_in, cmd.blue_in};
			end
		end
		fail_count    <= mismatches;
		pending_count <= pixel_queue.size();
	end

endmodule

>>> bench/bilinear_image_upscaler_unit_tb.sv
// Testbench top for the bilinear image upscaler: clock, reset, register setup and
// command stimulus, with biu_checker beside the block giving the failure count.
// Depends on biu_pkg, biu_checker and bilinear_image_upscaler_unit.
`timescale 1ns / 1ps
module bilinear_image_upscaler_unit_tb;
	import biu_pkg::*;

	localparam int SRC_MAX_W     = 256;
	localparam int SRC_MAX_H     = 256;
	localparam int SETTLE_CYCLES = 10;
	localparam int IDLE_LIMIT    = 2000;
	localparam int COORD_MAX     = 4095;
	localparam int STEP_MAX      = 131071;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	in_item_t                  cmd;
	logic                      done;
	out_item_t                 result;
	logic                      write_enable;
	logic [CFG_INDEX_BITS-1:0] reg_index;
	logic [CFG_DATA_BITS-1:0]  write_data;
	int                        fail_count;
	int                        pending_count;
	int unsigned               idle_cycles;
	bit                        no_gaps;
	int unsigned               frame_w;
	int unsigned               frame_h;
	int unsigned               cur_step_x;
	int unsigned               cur_step_y;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	bilinear_image_upscaler_unit #(
		.MAX_SOURCE_WIDTH (SRC_MAX_W),
		.MAX_SOURCE_HEIGHT(SRC_MAX_H)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.done        (done),
		.result      (result),
		.write_enable(write_enable),
		.reg_index   (reg_index),
		.write_data  (write_data)
	);

	biu_checker #(
		.MAX_W(SRC_MAX_W),
		.MAX_H(SRC_MAX_H)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.done         (done),
		.result       (result),
		.write_enable (write_enable),
		.reg_index    (reg_index),
		.write_data   (write_data),
		.fail_count   (fail_count),
		.pending_count(pending_count)
	);

	// Watchdog: ends the run when nothing has moved for too long.
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((start && !busy) || done || write_enable)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// Present one command transaction and hold it until it is accepted.
	task automatic send_item(logic op, int unsigned col, int unsigned row,
		logic [7:0] r, logic [7:0] g, logic [7:0] b);
		while (!no_gaps && $urandom_range(99) < 16) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd   <= '{op, COORD_BITS'(col), COORD_BITS'(row), r, g, b};
		do
			@(posedge clk);
		while (busy);
	endtask

	// Wait until every request has returned and the pipeline has emptied.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write; the caller drops the write enable after the last one.
	task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, int unsigned data);
		write_enable <= 1'b1;
		reg_index    <= idx;
		write_data   <= CFG_DATA_BITS'(data);
		@(posedge clk);
	endtask

	// Set up all four registers while the block is idle.
	task automatic configure(int unsigned w, int unsigned h, int unsigned sx, int unsigned sy);
		drain();
		write_reg(REG_SOURCE_WIDTH, w);
		write_reg(REG_SOURCE_HEIGHT, h);
		write_reg(REG_STEP_X, sx);
		write_reg(REG_STEP_Y, sy);
		write_enable <= 1'b0;
		// The frame in use, as the block clamps it, bounds what may be read.
		frame_w    = (w == 0) ? 1 : (w > SRC_MAX_W) ? SRC_MAX_W : w;
		frame_h    = (h == 0) ? 1 : (h > SRC_MAX_H) ? SRC_MAX_H : h;
		cur_step_x = sx;
		cur_step_y = sy;
	endtask

	// Channel values leaning towards the extremes.
	function automatic logic [7:0] rand_chan();
		if ($urandom_range(3) == 0)
			return $urandom_range(1) ? 8'hFF : 8'h00;
		return 8'($urandom_range(255));
	endfunction

	// Fill the whole frame in use so that no request reads an unwritten pixel.
	task automatic load_frame();
		for (int unsigned r = 0; r < frame_h; r++)
			for (int unsigned c = 0; c < frame_w; c++)
				send_item(OP_WRITE, c, r, rand_chan(), rand_chan(), rand_chan());
	endtask

	// Output coordinates that land inside the frame, with a little margin past it.
	function automatic int unsigned request_span(int unsigned size, int unsigned step);
		longint unsigned span;
		if (step == 0)
			return COORD_MAX;
		span = ((longint'(size) + 2) << FRAC_BITS) / step;
		return (span > COORD_MAX) ? COORD_MAX : int'(span);
	endfunction

	function automatic int unsigned rand_coord(int unsigned size, int unsigned step);
		if ($urandom_range(9) == 0)
			return $urandom_range(COORD_MAX);
		return $urandom_range(request_span(size, step));
	endfunction

	// Random mix of requests, in-frame writes and out-of-frame writes.
	task automatic run_random(int n);
		int count;
		int pick;
		count = 0;
		while (count < n) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				send_item(OP_REQUEST, rand_coord(frame_w, cur_step_x),
					rand_coord(frame_h, cur_step_y), rand_chan(), rand_chan(), rand_chan());
				count++;
			end else if (pick < 85) begin
				send_item(OP_WRITE, $urandom_range(frame_w - 1), $urandom_range(frame_h - 1),
					rand_chan(), rand_chan(), rand_chan());
				count++;
			end else if ($urandom_range(1)) begin
				send_item(OP_WRITE, $urandom_range(COORD_MAX, frame_w), $urandom_range(COORD_MAX),
					rand_chan(), rand_chan(), rand_chan());
			end else begin
				send_item(OP_WRITE, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX, frame_h),
					rand_chan(), rand_chan(), rand_chan());
			end
		end
	endtask

	function automatic int unsigned pick_step();
		case ($urandom_range(4))
			0:       return 65536 / $urandom_range(8, 1);
			1:       return $urandom_range(STEP_MAX);
			2:       return $urandom_range(65536, 1);
			default: return 65536 / $urandom_range(4, 1);
		endcase
	endfunction

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = '0;
		write_enable = 1'b0;
		reg_index    = REG_SOURCE_WIDTH;
		write_data   = '0;
		no_gaps      = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Two by two frame at double scale: corners, midpoints and clamping.
		configure(2, 2, 32768, 32768);
		send_item(OP_WRITE, 0, 0, 8'h00, 8'h00, 8'h00);
		send_item(OP_WRITE, 1, 0, 8'hFF, 8'hFF, 8'hFF);
		send_item(OP_WRITE, 0, 1, 8'hFF, 8'h00, 8'hFF);
		send_item(OP_WRITE, 1, 1, 8'h00, 8'hFF, 8'h00);
		send_item(OP_REQUEST, 0, 0, 8'h00, 8'h00, 8'h00);
		send_item(OP_REQUEST, 1, 0, 8'hFF, 8'hFF, 8'hFF);
		send_item(OP_REQUEST, 0, 1, 8'h00, 8'h00, 8'h00);
		send_item(OP_REQUEST, 1, 1, 8'hFF, 8'hFF, 8'hFF);
		send_item(OP_REQUEST, 2, 2, 8'h00, 8'h00, 8'h00);
		send_item(OP_REQUEST, 3, 1, 8'h00, 8'h00, 8'h00);
		send_item(OP_REQUEST, COORD_MAX, COORD_MAX, 8'h00, 8'h00, 8'h00);
		send_item(OP_REQUEST, 0, COORD_MAX, 8'h00, 8'h00, 8'h00);
		send_item(OP_REQUEST, COORD_MAX, 0, 8'h00, 8'h00, 8'h00);
		// Writes outside the frame must leave the stored pixels alone.
		send_item(OP_WRITE, 2, 0, 8'h12, 8'h34, 8'h56);
		send_item(OP_WRITE, 0, 2, 8'h65, 8'h43, 8'h21);
		send_item(OP_WRITE, COORD_MAX, COORD_MAX, 8'hFF, 8'hFF, 8'hFF);
		send_item(OP_REQUEST, 1, 1, 8'h00, 8'h00, 8'h00);
		send_item(OP_REQUEST, 2, 0, 8'h00, 8'h00, 8'h00);
		send_item(OP_REQUEST, 0, 2, 8'h00, 8'h00, 8'h00);

		// Fixed settings at extreme values: zero in every register, the top width and step x.
		configure(0, 0, 0, 0);
		load_frame();
		run_random(20);
		configure(511, 1, 65536, 1);
		load_frame();
		run_random(20);
		configure(1, 256, 1, 65536);
		load_frame();
		run_random(20);
		// One phase runs back to back with no gaps at all.
		no_gaps = 1'b1;
		configure(8, 8, STEP_MAX, 21845);
		load_frame();
		run_random(30);
		no_gaps = 1'b0;
		configure(5, 3, 13107, 43690);
		load_frame();
		run_random(20);

		// Random settings with small frames.
		for (int p = 0; p < 2; p++) begin
			configure($urandom_range(6, 1), $urandom_range(6, 1), pick_step(), pick_step());
			load_frame();
			run_random(10);
		end

		drain();
		if (fail_count == 0 && pending_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
